### rtl/core/brd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brd_pkg: shared types and constants of the broadcast ring store
// Transaction payload structs, command codes, pointer-table operations and
// the default sizes handed to the top level.
// ----------------------------------------------------------------------------
package brd_pkg;

  // Default sizes of the store.
  localparam int DEF_RING_DEPTH    = 16;
  localparam int DEF_NUM_CONSUMERS = 4;
  localparam int DEF_MAX_LEN       = 256;

  // A drain never returns more entries than this.
  localparam int MAX_DRAIN = 16;

  // Command codes carried in the cmd field.
  typedef enum logic [2:0] {
    CMD_CLEAR    = 3'd0,
    CMD_REGISTER = 3'd1,
    CMD_PUSH     = 3'd2,
    CMD_DRAIN    = 3'd3,
    CMD_COUNT    = 3'd4
  } cmd_e;

  // Request transaction.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  consumer;
    logic [63:0] payload;
    logic [7:0]  length;
    logic [4:0]  max_items;
  } req_t;

  // Response transaction.
  typedef struct packed {
    logic        granted;
    logic [1:0]  new_id;
    logic        item_valid;
    logic [63:0] item_payload;
    logic [7:0]  item_length;
    logic [4:0]  entry_count;
    logic        last;
  } rsp_t;

  // One stored ring entry.
  typedef struct packed {
    logic [63:0] payload;
    logic [7:0]  length;
  } entry_t;

  // Operation applied to the ring pointer table.
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } ptr_op_t;

endpackage

### rtl/core/brd_entry_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brd_entry_mem: shared entry store
// Single-port-write, single-port-read synchronous RAM holding the entries of
// all rings. Read data is registered and appears in the cycle after the read.
// ----------------------------------------------------------------------------
module brd_entry_mem
  import brd_pkg::*;
#(
  parameter int DEPTH  = DEF_NUM_CONSUMERS * DEF_RING_DEPTH,
  parameter int ADDR_W = $clog2(DEF_NUM_CONSUMERS * DEF_RING_DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  entry_t            wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output entry_t            rdata
);

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/brd_ring_ptrs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brd_ring_ptrs: ring pointer table
// Head and fill of every consumer ring. One ring is addressed per cycle; a
// push either appends or, on a full ring, overwrites the oldest entry.
// ----------------------------------------------------------------------------
module brd_ring_ptrs
  import brd_pkg::*;
#(
  parameter int RING_DEPTH    = DEF_RING_DEPTH,
  parameter int NUM_CONSUMERS = DEF_NUM_CONSUMERS,
  localparam int HEAD_W = $clog2(RING_DEPTH),
  localparam int FILL_W = $clog2(RING_DEPTH + 1),
  localparam int CID_W  = (NUM_CONSUMERS > 1) ? $clog2(NUM_CONSUMERS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  ptr_op_t           op,
  input  logic [CID_W-1:0]  idx,
  output logic [HEAD_W-1:0] head_q,
  output logic [FILL_W-1:0] fill_q,
  output logic [HEAD_W-1:0] push_slot
);

  localparam int SUM_W = FILL_W + 1;

  logic [HEAD_W-1:0] head [NUM_CONSUMERS];
  logic [FILL_W-1:0] fill [NUM_CONSUMERS];

  logic              full;
  logic [HEAD_W-1:0] head_inc;
  logic [SUM_W-1:0]  tail_sum;
  logic [SUM_W-1:0]  tail_wrap;

  // Pointers of the addressed ring and the slot a push would write.
  always_comb begin
    head_q    = head[idx];
    fill_q    = fill[idx];
    full      = (fill_q == FILL_W'(RING_DEPTH));
    head_inc  = (head_q == HEAD_W'(RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
    tail_sum  = SUM_W'(head_q) + SUM_W'(fill_q);
    tail_wrap = (tail_sum >= SUM_W'(RING_DEPTH)) ? tail_sum - SUM_W'(RING_DEPTH)
                                                 : tail_sum;
    push_slot = full ? head_q : tail_wrap[HEAD_W-1:0];
  end

  // Pointer updates: clear empties every ring at once.
  always_ff @(posedge clk) begin
    if (rst || op.clear) begin
      for (int i = 0; i < NUM_CONSUMERS; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else if (op.push) begin
      if (full) begin
        head[idx] <= head_inc;
      end else begin
        fill[idx] <= fill_q + 1'b1;
      end
    end else if (op.pop) begin
      head[idx] <= head_inc;
      fill[idx] <= fill_q - 1'b1;
    end
  end

endmodule

### rtl/core/broadcast_ring_drop_oldest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// broadcast_ring_drop_oldest: fan-out ring store
// Top level: command sequencer, registration counter and response register.
// ----------------------------------------------------------------------------
// One request transaction is worked on at a time; the response sits in an
// output register, so the next request is taken while a final response still
// waits. A push writes one entry per registered consumer into the single
// write port of the shared entry RAM, so it writes them one after another. A
// drain pops one entry at a time, each through pointer update and RAM read,
// registered read data and response load. Any cycle in which the response
// register is still full adds a stall before the next response is loaded.
// The entry RAM holds no valid bits and needs no clearing pass after reset;
// only entries that were pushed are ever read.
module broadcast_ring_drop_oldest
  import brd_pkg::*;
#(
  parameter int RING_DEPTH    = DEF_RING_DEPTH,
  parameter int NUM_CONSUMERS = DEF_NUM_CONSUMERS,
  parameter int MAX_LEN       = DEF_MAX_LEN
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int HEAD_W  = $clog2(RING_DEPTH);
  localparam int FILL_W  = $clog2(RING_DEPTH + 1);
  localparam int CID_W   = (NUM_CONSUMERS > 1) ? $clog2(NUM_CONSUMERS) : 1;
  localparam int RC_W    = $clog2(NUM_CONSUMERS + 1);
  localparam int MEM_D   = NUM_CONSUMERS * RING_DEPTH;
  localparam int ADDR_W  = $clog2(MEM_D);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PUSH,
    S_DRAIN_RD,
    S_DRAIN_WAIT,
    S_SEND
  } state_t;

  state_t            state;
  req_t              item;
  logic [4:0]        maxi;
  logic [RC_W-1:0]   reg_count;
  logic [RC_W-1:0]   pidx;
  logic [4:0]        dcount;
  rsp_t              res;
  rsp_t              exec_rsp;
  rsp_t              drain_rsp;

  ptr_op_t           ptr_op;
  logic [CID_W-1:0]  ptr_idx;
  logic [HEAD_W-1:0] head_q;
  logic [FILL_W-1:0] fill_q;
  logic [HEAD_W-1:0] push_slot;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  entry_t            mem_wdata;
  entry_t            mem_rdata;

  logic              cons_ok;
  logic              len_ok;
  logic              drain_go;
  logic              out_free;

  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;

  // Request qualifiers.
  assign cons_ok  = (32'(item.consumer) < NUM_CONSUMERS);
  assign len_ok   = (item.length != '0) && (32'(item.length) < MAX_LEN);
  assign drain_go = cons_ok && (dcount < maxi) && (fill_q != '0);

  assign mem_wdata.payload = item.payload;
  assign mem_wdata.length  = item.length;

  // Single-response result of the current command. A drain that pops
  // nothing also closes with this final response, zero but for last.
  always_comb begin
    exec_rsp      = '0;
    exec_rsp.last = 1'b1;
    case (item.cmd)
      CMD_REGISTER: begin
        if (reg_count < RC_W'(NUM_CONSUMERS)) begin
          exec_rsp.granted = 1'b1;
          exec_rsp.new_id  = 2'(reg_count);
        end
      end
      CMD_COUNT: begin
        if (cons_ok) begin
          exec_rsp.entry_count = 5'(fill_q);
        end
      end
      default: begin
      end
    endcase
  end

  // Response carrying one drained entry; pointers already reflect the pop.
  always_comb begin
    drain_rsp              = '0;
    drain_rsp.item_valid   = 1'b1;
    drain_rsp.item_payload = mem_rdata.payload;
    drain_rsp.item_length  = mem_rdata.length;
    drain_rsp.entry_count  = dcount;
    drain_rsp.last         = (dcount == maxi) || (fill_q == '0);
  end

  // Pointer table and entry RAM control for the current step.
  always_comb begin
    ptr_op    = '0;
    ptr_idx   = CID_W'(item.consumer);
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = ADDR_W'(ADDR_W'(pidx) * ADDR_W'(RING_DEPTH) + ADDR_W'(push_slot));
    mem_raddr = ADDR_W'(ADDR_W'(item.consumer) * ADDR_W'(RING_DEPTH) + ADDR_W'(head_q));
    case (state)
      S_EXEC: begin
        ptr_op.clear = (item.cmd == CMD_CLEAR);
      end
      S_PUSH: begin
        ptr_idx     = pidx[CID_W-1:0];
        ptr_op.push = 1'b1;
        mem_we      = 1'b1;
      end
      S_DRAIN_RD: begin
        ptr_op.pop = drain_go;
        mem_re     = drain_go;
      end
      default: begin
      end
    endcase
  end

  // Sequencer, registration counter and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      reg_count <= '0;
    end else begin
      if (state == S_SEND && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            item  <= req;
            maxi  <= (req.max_items > 5'(MAX_DRAIN)) ? 5'(MAX_DRAIN) : req.max_items;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res    <= exec_rsp;
          dcount <= '0;
          pidx   <= '0;
          if (item.cmd == CMD_DRAIN) begin
            state <= S_DRAIN_RD;
          end else if (item.cmd == CMD_PUSH && len_ok && reg_count != '0) begin
            state <= S_PUSH;
          end else begin
            state <= S_SEND;
          end
          case (item.cmd)
            CMD_CLEAR: begin
              reg_count <= '0;
            end
            CMD_REGISTER: begin
              if (reg_count < RC_W'(NUM_CONSUMERS)) begin
                reg_count <= reg_count + 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        S_PUSH: begin
          pidx <= pidx + 1'b1;
          if (pidx + 1'b1 == reg_count) begin
            state <= S_SEND;
          end
        end
        S_DRAIN_RD: begin
          if (drain_go) begin
            dcount <= dcount + 1'b1;
            state  <= S_DRAIN_WAIT;
          end else begin
            res   <= exec_rsp;
            state <= S_SEND;
          end
        end
        S_DRAIN_WAIT: begin
          // Read data is ready now.
          res   <= drain_rsp;
          state <= S_SEND;
        end
        S_SEND: begin
          if (out_free) begin
            rsp   <= res;
            state <= res.last ? S_IDLE : S_DRAIN_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  brd_ring_ptrs #(
    .RING_DEPTH    (RING_DEPTH),
    .NUM_CONSUMERS (NUM_CONSUMERS)
  ) u_ptrs (
    .clk       (clk),
    .rst       (rst),
    .op        (ptr_op),
    .idx       (ptr_idx),
    .head_q    (head_q),
    .fill_q    (fill_q),
    .push_slot (push_slot)
  );

  brd_entry_mem #(
    .DEPTH  (MEM_D),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

### rtl/core/brd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brd_checker: port-level checks of the broadcast ring store
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module brd_checker
  import brd_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  // A stalled response transaction holds its valid and payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // No new request is taken while a drain still has responses to give.
  a_no_req_mid_drain: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> !req_ready)
    else $error("request accepted in the middle of a drain");

  // A response without a drained entry is always the final one.
  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.item_valid |-> rsp.last)
    else $error("response without entry is not final");

  // A drained entry carries a running count between one and the drain limit.
  a_item_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.item_valid |-> rsp.entry_count != '0 &&
      rsp.entry_count <= 5'(MAX_DRAIN) && !rsp.granted)
    else $error("drained entry has a bad count");

endmodule

bind broadcast_ring_drop_oldest brd_checker u_brd_checker (.*);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the broadcast ring store
// Requests are driven on the falling edge and both handshakes are sampled on
// the rising edge. A mirror of the rings predicts every response of each
// accepted request and checks the responses in order, field by field. The run
// starts with a directed pass, then random traffic in fill, drain and mixed
// phases, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb;
  import brd_pkg::*;

  localparam int NUM_CONS      = DEF_NUM_CONSUMERS;
  localparam int DEPTH         = DEF_RING_DEPTH;
  localparam int LEN_LIMIT     = DEF_MAX_LEN;
  localparam int RANDOM_ITEMS  = 288;
  localparam int SETTLE_CYCLES = 64;
  localparam int REPORT_LIMIT  = 10;

  // Command codes the block does not define.
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_e;

  // Mirror of the consumer rings and the responses still due.
  class fanout_mirror;
    int unsigned reg_count;
    int unsigned head [NUM_CONS];
    int unsigned fill [NUM_CONS];
    entry_t      entry_mem [NUM_CONS * DEPTH];
    rsp_t        due_responses [$];
    int          failures;

    function new();
      failures = 0;
      clear_rings();
    endfunction

    function void clear_rings();
      reg_count = 0;
      for (int c = 0; c < NUM_CONS; c++) begin
        head[c] = 0;
        fill[c] = 0;
      end
    endfunction

    // A full ring gives up its oldest entry to make room.
    function void store_entry(int unsigned c, logic [63:0] pay, logic [7:0] len);
      int unsigned slot;
      if (fill[c] >= DEPTH) begin
        slot = head[c];
        head[c] = (head[c] + 1) % DEPTH;
      end else begin
        slot = (head[c] + fill[c]) % DEPTH;
        fill[c]++;
      end
      entry_mem[c * DEPTH + slot] = {pay, len};
    endfunction

    function int pending();
      return due_responses.size();
    endfunction

    // Work out every response that one accepted request causes.
    function void note_request(req_t r);
      rsp_t        res;
      int unsigned c;
      int unsigned lim;
      int unsigned n;
      res = '0;
      res.last = 1'b1;
      c = r.consumer;
      case (r.cmd)
        CMD_CLEAR: begin
          clear_rings();
          due_responses.push_back(res);
        end
        CMD_REGISTER: begin
          if (reg_count < NUM_CONS) begin
            res.granted = 1'b1;
            res.new_id  = reg_count[1:0];
            reg_count++;
          end
          due_responses.push_back(res);
        end
        CMD_PUSH: begin
          if (r.length != 0 && r.length < LEN_LIMIT) begin
            for (int unsigned i = 0; i < reg_count; i++) store_entry(i, r.payload, r.length);
          end
          due_responses.push_back(res);
        end
        CMD_DRAIN: begin
          lim = (r.max_items > MAX_DRAIN) ? MAX_DRAIN : r.max_items;
          n = 0;
          if (c < NUM_CONS) begin
            while (n < lim && fill[c] > 0) begin
              res = '0;
              res.item_valid   = 1'b1;
              res.item_payload = entry_mem[c * DEPTH + head[c]].payload;
              res.item_length  = entry_mem[c * DEPTH + head[c]].length;
              res.entry_count  = 5'(n + 1);
              res.last         = (n + 1 == lim) || (fill[c] == 1);
              due_responses.push_back(res);
              head[c] = (head[c] + 1) % DEPTH;
              fill[c]--;
              n++;
            end
          end
          // Nothing popped: a single empty response closes the drain.
          if (n == 0) begin
            res = '0;
            res.last = 1'b1;
            due_responses.push_back(res);
          end
        end
        CMD_COUNT: begin
          if (c < NUM_CONS) res.entry_count = 5'(fill[c]);
          due_responses.push_back(res);
        end
        default: begin
          due_responses.push_back(res);
        end
      endcase
    endfunction

    function string describe(rsp_t x);
      return $sformatf("granted=%0d new_id=%0d valid=%0d payload=%h length=%0d count=%0d last=%0d",
                       x.granted, x.new_id, x.item_valid, x.item_payload, x.item_length,
                       x.entry_count, x.last);
    endfunction

    // Compare one accepted response with the oldest one still due.
    function void check_response(rsp_t got);
      rsp_t exp;
      bit   bad;
      if (due_responses.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("ERROR: unexpected response %s", describe(got));
        return;
      end
      exp = due_responses.pop_front();
      bad = (got.granted !== exp.granted) || (got.new_id !== exp.new_id) ||
            (got.item_valid !== exp.item_valid) || (got.item_payload !== exp.item_payload) ||
            (got.item_length !== exp.item_length) || (got.entry_count !== exp.entry_count) ||
            (got.last !== exp.last);
      if (bad) begin
        failures++;
        if (failures <= REPORT_LIMIT) begin
          $display("ERROR: response mismatch at %0t", $realtime);
          $display("  expected %s", describe(exp));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  fanout_mirror sb;
  bit           steady_run;

  broadcast_ring_drop_oldest uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Random idle cycle, suppressed during the steady stretch.
  function automatic bit take_gap();
    return !steady_run && ($urandom_range(0, 99) < 13);
  endfunction

  // Observe both handshakes on the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_request(req);
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
    end
  end

  // Response side backpressure.
  initial begin
    rsp_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      rsp_ready <= !take_gap();
      @(negedge clk);
    end
  end

  // Present one request transaction and hold it until accepted.
  task automatic send_request(input req_t r);
    @(negedge clk);
    while (take_gap()) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic issue(input logic [2:0] cmd, input logic [1:0] cons,
                       input logic [63:0] pay, input logic [7:0] len,
                       input logic [4:0] maxi);
    req_t r;
    r.cmd       = cmd;
    r.consumer  = cons;
    r.payload   = pay;
    r.length    = len;
    r.max_items = maxi;
    send_request(r);
  endtask

  // Random request whose command mix depends on the traffic phase.
  function automatic req_t random_request(input mix_e mode);
    req_t r;
    int   roll;
    int   push_pct;
    int   drain_pct;
    r.consumer  = 2'($urandom_range(0, NUM_CONS - 1));
    r.payload   = {$urandom, $urandom};
    r.length    = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    r.max_items = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                             : 5'($urandom_range(0, MAX_DRAIN));
    case (mode)
      MODE_FILL:  begin push_pct = 66; drain_pct = 8;  end
      MODE_DRAIN: begin push_pct = 25; drain_pct = 45; end
      default:    begin push_pct = 45; drain_pct = 25; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < push_pct) r.cmd = CMD_PUSH;
    else if (roll < push_pct + drain_pct) r.cmd = CMD_DRAIN;
    else if (roll < push_pct + drain_pct + 12) r.cmd = CMD_COUNT;
    else if (roll < push_pct + drain_pct + 20) r.cmd = CMD_REGISTER;
    else if (roll < push_pct + drain_pct + 23) r.cmd = CMD_CLEAR;
    else r.cmd = 3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST));
    return r;
  endfunction

  // Main stimulus.
  initial begin
    mix_e mode;
    sb         = new();
    steady_run = 1'b0;
    mode       = MODE_MIXED;
    rst        = 1'b1;
    req_valid  = 1'b0;
    req        = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty store and a push with nobody registered.
    issue(CMD_COUNT, 2'd0, 64'd0, 8'd0, 5'd0);
    issue(CMD_DRAIN, 2'd0, 64'd0, 8'd0, 5'(MAX_DRAIN));
    issue(CMD_PUSH, 2'd0, 64'd1, 8'd1, 5'd0);
    // Take every id, then one refused registration.
    repeat (NUM_CONS + 1) issue(CMD_REGISTER, 2'd0, 64'd0, 8'd0, 5'd0);
    // Length extremes, including the ignored zero length.
    issue(CMD_PUSH, 2'd0, '1, 8'd255, 5'd0);
    issue(CMD_PUSH, 2'd0, 64'd0, 8'd1, 5'd0);
    issue(CMD_PUSH, 2'd0, 64'hA5A5_5A5A_0F0F_F0F0, 8'd0, 5'd0);
    issue(CMD_COUNT, 2'd3, 64'd0, 8'd0, 5'd0);
    // Drain with zero limit, then with a limit above the cap.
    issue(CMD_DRAIN, 2'd1, 64'd0, 8'd0, 5'd0);
    issue(CMD_DRAIN, 2'd1, 64'd0, 8'd0, 5'd31);
    issue(CMD_COUNT, 2'd1, 64'd0, 8'd0, 5'd0);
    issue(CMD_DRAIN, 2'd2, 64'd0, 8'd0, 5'd1);
    // Undefined commands change nothing.
    issue(CMD_UNUSED_FIRST, 2'd2, '1, 8'd7, 5'd3);
    issue(CMD_UNUSED_LAST, 2'd3, 64'd5, 8'd9, 5'd16);
    // Clear forgets rings and registrations.
    issue(CMD_CLEAR, 2'd0, 64'd0, 8'd0, 5'd0);
    issue(CMD_COUNT, 2'd0, 64'd0, 8'd0, 5'd0);
    issue(CMD_DRAIN, 2'd3, 64'd0, 8'd0, 5'(MAX_DRAIN));
    issue(CMD_REGISTER, 2'd0, 64'd0, 8'd0, 5'd0);

    // Random traffic in phases of thirty transactions.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 30 == 0) mode = mix_e'($urandom_range(0, 2));
      steady_run = (i >= 120 && i < 200);
      send_request(random_request(mode));
    end
    steady_run = 1'b0;

    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("broadcast_ring_drop_oldest test passed");
    end else begin
      $display("broadcast_ring_drop_oldest test failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8_000_000;
    $display("broadcast_ring_drop_oldest test failed");
    $finish;
  end

endmodule
